// File: rtl/ntt_pkg.sv
// Shared types and constants of the nearest target tracker.
package ntt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COORD_W = 16;
	localparam int TAG_W = 8;
	localparam int DIST_W = 2 * COORD_W + 1;
	localparam int RADIUS_W = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'd4194304;

	// Register index, taken from the word address of the APB port.
	localparam logic REG_RADIUS = 1'b0;

	// Item operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POSE = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TAG_W-1:0]   tag;
	} point_t;

	localparam int POINT_W = $bits(point_t);

endpackage

// File: rtl/ntt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ntt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ntt_dist.sv
// Squared Euclidean distance unit: squares registered, sum formed after the register.
module ntt_dist import ntt_pkg::*; (
	input  logic               clk,
	input  logic [COORD_W-1:0] ax,
	input  logic [COORD_W-1:0] ay,
	input  logic [COORD_W-1:0] bx,
	input  logic [COORD_W-1:0] by,
	output logic [DIST_W-1:0]  sq_dist
);

	logic [COORD_W-1:0]   dx;
	logic [COORD_W-1:0]   dy;
	logic [2*COORD_W-1:0] sq_x_q;
	logic [2*COORD_W-1:0] sq_y_q;

	always_comb begin
		dx = (ax > bx) ? (ax - bx) : (bx - ax);
		dy = (ay > by) ? (ay - by) : (by - ay);
	end

	always_ff @(posedge clk) begin
		sq_x_q <= (2*COORD_W)'(dx) * (2*COORD_W)'(dx);
		sq_y_q <= (2*COORD_W)'(dy) * (2*COORD_W)'(dy);
	end

	assign sq_dist = {1'b0, sq_x_q} + {1'b0, sq_y_q};

endmodule

// File: rtl/nearest_target_tracker.sv
// Top level of the nearest target tracker: sequencer, registers and APB port.
//
//   channel  | handshake                         | content
//   ---------+-----------------------------------+--------------------------------------
//   item     | item_valid / item_ready           | op, coord_x, coord_y, point_tag
//   result   | result_valid / result_ready       | target_*, captured*, dropped flags
//   config   | psel, penable, pwrite, pready = 1 | capture_radius_sq at byte address 0
//
// One word is handled at a time. A dropped insert goes straight to its result. An
// accepted insert rescans all N entries, where N is the table fill after the insert;
// the nearest-point scan reads one table entry a cycle through the single RAM read port.
// A pose word without capture only checks the target distance; a capture adds the
// removal shift of (N - index - 1) entries plus a rescan of the remaining points. Reset
// clears all control state and needs no clearing pass: only entries below the fill count
// are ever read. A result waits in its output register while the next word is taken in.
module nearest_target_tracker import ntt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               op,
	input  logic [COORD_W-1:0] coord_x,
	input  logic [COORD_W-1:0] coord_y,
	input  logic [TAG_W-1:0]   point_tag,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output logic               target_valid,
	output logic               target_changed,
	output logic [COORD_W-1:0] target_x,
	output logic [COORD_W-1:0] target_y,
	output logic [TAG_W-1:0]   target_tag,
	output logic               captured,
	output logic [TAG_W-1:0]   captured_tag,
	output logic               dropped,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHK1  = 3'd1;
	localparam logic [2:0] ST_CHK2  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       tidx_q;
	point_t              tgt_q;
	logic [COORD_W-1:0]  pose_x_q;
	logic [COORD_W-1:0]  pose_y_q;
	logic [CW-1:0]       ptr_q;

	// Read pipeline: s1 holds the RAM output, s2 holds the distance.
	logic                v_s1;
	logic [IW-1:0]       idx_s1;
	logic                v_s2;
	logic [IW-1:0]       idx_s2;
	point_t              data_s2;

	logic [DIST_W-1:0]   best_d_q;
	logic [IW-1:0]       best_idx_q;
	point_t              best_data_q;

	logic                changed_q;
	logic                captured_q;
	logic [TAG_W-1:0]    cap_tag_q;
	logic                dropped_q;

	logic                res_valid_q;
	logic                res_tvalid_q;
	logic                res_changed_q;
	point_t              res_tgt_q;
	logic                res_captured_q;
	logic [TAG_W-1:0]    res_cap_tag_q;
	logic                res_dropped_q;

	logic                item_acc;
	logic                cfg_wr;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	point_t              rdata;
	logic                we;
	logic [IW-1:0]       waddr;
	point_t              wdata;
	logic [COORD_W-1:0]  dist_bx;
	logic [COORD_W-1:0]  dist_by;
	logic [DIST_W-1:0]   sq_dist;
	logic                table_full;
	logic                scan_done;
	logic                shift_done;
	logic                out_free;

	// Configuration port: the register sits at word 0, other words read as zero.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_RADIUS) ? radius_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata;
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign table_full = (count_q == CW'(TABLE_DEPTH));

	// Entries are fetched in order while the issue pointer is below the fill count.
	assign rd_en   = (state_q == ST_SHIFT || state_q == ST_SCAN) && (ptr_q < count_q);
	assign rd_addr = ptr_q[IW-1:0];

	// An insert writes at the fill count; the removal shift writes each entry one below.
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IW-1:0];
		wdata = '{x: coord_x, y: coord_y, tag: point_tag};
		if (state_q == ST_IDLE) begin
			we = item_acc && op == OP_INSERT && !table_full;
		end else if (state_q == ST_SHIFT) begin
			we    = v_s1;
			waddr = idx_s1 - IW'(1);
			wdata = rdata;
		end
	end

	ntt_ram #(
		.WIDTH(POINT_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// The distance unit measures from the pose to the target during the capture check
	// and to each fetched entry during a scan.
	assign dist_bx = (state_q == ST_CHK1) ? tgt_q.x : rdata.x;
	assign dist_by = (state_q == ST_CHK1) ? tgt_q.y : rdata.y;

	ntt_dist u_dist (
		.clk    (clk),
		.ax     (pose_x_q),
		.ay     (pose_y_q),
		.bx     (dist_bx),
		.by     (dist_by),
		.sq_dist(sq_dist)
	);

	assign scan_done  = (state_q == ST_SCAN) && !rd_en && !v_s1 && !v_s2;
	assign shift_done = (state_q == ST_SHIFT) && !rd_en && !v_s1;
	assign out_free   = !res_valid_q || result_ready;

	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr;
		idx_s2  <= idx_s1;
		data_s2 <= rdata;
		// Strict compare keeps the lowest index on a tie.
		if (v_s2 && (idx_s2 == '0 || sq_dist < best_d_q)) begin
			best_d_q    <= sq_dist;
			best_idx_q  <= idx_s2;
			best_data_q <= data_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			tidx_q     <= '0;
			tgt_q      <= '0;
			pose_x_q   <= '0;
			pose_y_q   <= '0;
			ptr_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			changed_q  <= 1'b0;
			captured_q <= 1'b0;
			cap_tag_q  <= '0;
			dropped_q  <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1 && (state_q == ST_SCAN);
			if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						changed_q  <= 1'b0;
						captured_q <= 1'b0;
						cap_tag_q  <= '0;
						dropped_q  <= 1'b0;
						if (op == OP_INSERT) begin
							if (table_full) begin
								dropped_q <= 1'b1;
								state_q   <= ST_FIN;
							end else begin
								count_q <= count_q + CW'(1);
								ptr_q   <= '0;
								state_q <= ST_SCAN;
							end
						end else begin
							pose_x_q <= coord_x;
							pose_y_q <= coord_y;
							state_q  <= ST_CHK1;
						end
					end
				end
				ST_CHK1: begin
					state_q <= ST_CHK2;
				end
				ST_CHK2: begin
					if (count_q != '0 && CW'(tidx_q) < count_q &&
					    sq_dist < {1'b0, radius_q}) begin
						captured_q <= 1'b1;
						cap_tag_q  <= tgt_q.tag;
						ptr_q      <= CW'(tidx_q) + CW'(1);
						state_q    <= ST_SHIFT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SHIFT: begin
					if (shift_done) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= ST_FIN;
						end else begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						tidx_q    <= best_idx_q;
						tgt_q     <= best_data_q;
						changed_q <= 1'b1;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: loaded once a word is finished and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			res_tvalid_q   <= (count_q != '0);
			res_changed_q  <= changed_q;
			res_tgt_q      <= (count_q != '0) ? tgt_q : '0;
			res_captured_q <= captured_q;
			res_cap_tag_q  <= cap_tag_q;
			res_dropped_q  <= dropped_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign target_valid   = res_tvalid_q;
	assign target_changed = res_changed_q;
	assign target_x       = res_tgt_q.x;
	assign target_y       = res_tgt_q.y;
	assign target_tag     = res_tgt_q.tag;
	assign captured       = res_captured_q;
	assign captured_tag   = res_cap_tag_q;
	assign dropped        = res_dropped_q;

endmodule

// File: tb/nearest_target_tracker_checker.sv
// Checker of the nearest target tracker: predicts each result word and compares it.
module nearest_target_tracker_checker import ntt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic               op,
	input  logic [COORD_W-1:0] coord_x,
	input  logic [COORD_W-1:0] coord_y,
	input  logic [TAG_W-1:0]   point_tag,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic               target_valid,
	input  logic               target_changed,
	input  logic [COORD_W-1:0] target_x,
	input  logic [COORD_W-1:0] target_y,
	input  logic [TAG_W-1:0]   target_tag,
	input  logic               captured,
	input  logic [TAG_W-1:0]   captured_tag,
	input  logic               dropped,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic               tvalid;
		logic               changed;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
		logic [TAG_W-1:0]   ttag;
		logic               cap;
		logic [TAG_W-1:0]   cap_tag;
		logic               drop;
	} outcome_t;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	// Predicted contents of the point table, the target and the pose.
	logic [COORD_W-1:0]  tbl_x [DEPTH];
	logic [COORD_W-1:0]  tbl_y [DEPTH];
	logic [TAG_W-1:0]    tbl_tag [DEPTH];
	int                  fill;
	int                  aim_idx;
	point_t              aim;
	logic [COORD_W-1:0]  here_x;
	logic [COORD_W-1:0]  here_y;
	logic [RADIUS_W-1:0] radius_sq;

	outcome_t outcome_q[$];
	int mismatches = 0;
	int queued = 0;
	int results_seen = 0;

	assign fail_count = mismatches;
	assign pending = queued;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	// Exact squared distance, wide enough for two full-range deltas.
	function automatic logic [DIST_W:0] span_sq(input logic [COORD_W-1:0] ax, ay, bx, by);
		logic [DIST_W:0] dx;
		logic [DIST_W:0] dy;
		dx = (DIST_W+1)'((ax > bx) ? ax - bx : bx - ax);
		dy = (DIST_W+1)'((ay > by) ? ay - by : by - ay);
		return dx * dx + dy * dy;
	endfunction

	// The nearest point to the pose becomes the target; ties keep the lowest index.
	function automatic void pick_nearest();
		logic [DIST_W:0] best_d;
		logic [DIST_W:0] d;
		int best;
		best = 0;
		best_d = span_sq(here_x, here_y, tbl_x[0], tbl_y[0]);
		for (int i = 1; i < fill; i++) begin
			d = span_sq(here_x, here_y, tbl_x[i], tbl_y[i]);
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		aim_idx = best;
		aim.x = tbl_x[best];
		aim.y = tbl_y[best];
		aim.tag = tbl_tag[best];
	endfunction

	function automatic outcome_t predict_word(input logic kind,
			input logic [COORD_W-1:0] cx, cy, input logic [TAG_W-1:0] tag);
		outcome_t o;
		o = '0;
		if (kind == OP_INSERT) begin
			if (fill >= DEPTH) begin
				o.drop = 1'b1;
			end else begin
				tbl_x[fill] = cx;
				tbl_y[fill] = cy;
				tbl_tag[fill] = tag;
				fill++;
				pick_nearest();
				o.changed = 1'b1;
			end
		end else begin
			here_x = cx;
			here_y = cy;
			if (fill > 0 && span_sq(here_x, here_y, aim.x, aim.y) < {2'b00, radius_sq}) begin
				o.cap = 1'b1;
				o.cap_tag = aim.tag;
				// Close the gap so the table keeps its order.
				for (int i = aim_idx; i < fill - 1; i++) begin
					tbl_x[i] = tbl_x[i + 1];
					tbl_y[i] = tbl_y[i + 1];
					tbl_tag[i] = tbl_tag[i + 1];
				end
				fill--;
				if (fill > 0) begin
					pick_nearest();
					o.changed = 1'b1;
				end
			end
		end
		o.tvalid = (fill > 0);
		if (o.tvalid) begin
			o.tx = aim.x;
			o.ty = aim.y;
			o.ttag = aim.tag;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			fill = 0;
			aim_idx = 0;
			aim = '0;
			here_x = '0;
			here_y = '0;
			radius_sq = RADIUS_RESET;
			outcome_q.delete();
			queued <= 0;
		end else begin
			// A result never belongs to a word taken in at the same edge, so pop first.
			if (result_valid && result_ready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = outcome_q.pop_front();
					compare_field("target_valid", target_valid, want.tvalid);
					compare_field("target_changed", target_changed, want.changed);
					compare_field("target_x", target_x, want.tx);
					compare_field("target_y", target_y, want.ty);
					compare_field("target_tag", target_tag, want.ttag);
					compare_field("captured", captured, want.cap);
					compare_field("captured_tag", captured_tag, want.cap_tag);
					compare_field("dropped", dropped, want.drop);
				end
			end
			if (item_valid && item_ready)
				outcome_q = {outcome_q, predict_word(op, coord_x, coord_y, point_tag)};
			// Writes to any other register index are ignored by the block.
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_RADIUS) begin
				if (pwrite)
					radius_sq = pwdata[RADIUS_W-1:0];
				else
					compare_field("prdata", prdata, radius_sq);
			end
			queued <= outcome_q.size();
		end
	end

endmodule

// File: tb/nearest_target_tracker_tb.sv
// Testbench top of the nearest target tracker: clock, reset, stimulus and verdict.
module nearest_target_tracker_tb;
	import ntt_pkg::*;

	// A capture of the first entry in a full table shifts and rescans the whole table, and the
	// receiver holds off for HOLD_CYCLES once, so the stall limit leaves a wide margin.
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_WORDS = 210;
	localparam int SEEN_DEPTH = 64;
	localparam logic [PADDR_W-1:0] ADDR_RADIUS = {REG_RADIUS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_RADIUS, 2'b00};
	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic               op = OP_INSERT;
	logic [COORD_W-1:0] coord_x = '0;
	logic [COORD_W-1:0] coord_y = '0;
	logic [TAG_W-1:0]   point_tag = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               target_valid;
	logic               target_changed;
	logic [COORD_W-1:0] target_x;
	logic [COORD_W-1:0] target_y;
	logic [TAG_W-1:0]   target_tag;
	logic               captured;
	logic [TAG_W-1:0]   captured_tag;
	logic               dropped;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int pending;
	int stall_cycles = 0;

	// Shared with the receiver: quiet_mode turns idling off on both sides, and
	// hold_req asks the receiver for one long hold-off.
	bit quiet_mode = 1'b0;
	bit hold_req = 1'b0;

	// Recently inserted points, used to aim poses at real targets and to insert
	// duplicates that force distance ties.
	logic [COORD_W-1:0] seen_x[$];
	logic [COORD_W-1:0] seen_y[$];
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;

	always #5 clk = ~clk;

	nearest_target_tracker u_dut (.*);

	nearest_target_tracker_checker u_checker (.*);

	// Offers one word after a random gap and returns at the edge that takes it in.
	// The valid stays high so that a following word can go out without a gap.
	task automatic send_word(input logic kind, input logic [COORD_W-1:0] cx, cy,
			input logic [TAG_W-1:0] tag);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(3, 0);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= kind;
		coord_x <= cx;
		coord_y <= cy;
		point_tag <= tag;
		do @(posedge clk); while (!item_ready);
		if (kind == OP_INSERT) begin
			seen_x = {seen_x, cx};
			seen_y = {seen_y, cy};
			if (seen_x.size() > SEEN_DEPTH) begin
				void'(seen_x.pop_front());
				void'(seen_y.pop_front());
			end
		end
	endtask

	// Stops offering words and waits until every predicted result has come back,
	// so the block is idle afterwards.
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One register access: a setup phase, then an access phase until pready.
	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Moves a coordinate by up to reach in a random direction, clamped to the range.
	function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base,
			input int unsigned reach);
		int unsigned delta;
		delta = $urandom_range(reach, 0);
		if ($urandom_range(1, 0))
			return (32'(base) + delta > 32'(COORD_MAX)) ? COORD_MAX :
				COORD_W'(32'(base) + delta);
		return (32'(base) < delta) ? '0 : COORD_W'(32'(base) - delta);
	endfunction

	// One random word. Most words are clustered around the phase center, and most
	// poses are aimed at a point that was inserted, so captures happen often; the
	// rest are full-range values, corners and exact copies of earlier points.
	task automatic send_random(input int unsigned insert_pct, input int unsigned spread);
		logic kind;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		int unsigned pick;
		int k;
		kind = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_POSE;
		pick = $urandom_range(19, 0);
		k = (seen_x.size() > 0) ? $urandom_range(seen_x.size() - 1, 0) : -1;
		if (pick < 2) begin
			cx = COORD_W'($urandom);
			cy = COORD_W'($urandom);
		end else if (pick < 3) begin
			cx = $urandom_range(1, 0) ? COORD_MAX : '0;
			cy = $urandom_range(1, 0) ? COORD_MAX : '0;
		end else if (pick < 5 && k >= 0) begin
			cx = seen_x[k];
			cy = seen_y[k];
		end else if (kind == OP_POSE && pick < 14 && k >= 0) begin
			cx = nudge(seen_x[k], spread / 4);
			cy = nudge(seen_y[k], spread / 4);
		end else begin
			cx = nudge(center_x, spread);
			cy = nudge(center_y, spread);
		end
		send_word(kind, cx, cy, TAG_W'($urandom));
	endtask

	// The receiver draws a gap before each result, and once takes a long hold-off
	// while the sender keeps offering words so that the block backs up.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = quiet_mode ? 0 : $urandom_range(3, 0);
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Ends the run when neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("nearest_target_tracker_tb NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [RADIUS_W-1:0] radius;
		int unsigned insert_pct;
		int unsigned spread;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// The radius register must read back its reset value.
		apb_access(1'b0, ADDR_RADIUS, '0);

		// Directed walk with the reset radius. A pose on the empty table only stores
		// the pose. The duplicate at the origin ties with the earlier one, and the
		// lower index must win. The far corner gives the largest possible distance.
		send_word(OP_POSE, '0, '0, 8'h00);
		send_word(OP_INSERT, COORD_MAX, COORD_MAX, 8'hFF);
		send_word(OP_INSERT, '0, '0, 8'h00);
		send_word(OP_INSERT, '0, '0, 8'h55);
		send_word(OP_POSE, COORD_MAX, COORD_MAX, 8'h00);
		send_word(OP_INSERT, 16'h8000, 16'h8000, 8'hAA);
		// Capture of the first entry shifts the whole table down.
		send_word(OP_POSE, COORD_MAX, COORD_MAX, 8'hFF);
		// Capture of the last entry, then a tie between the two origin points.
		send_word(OP_POSE, 16'h8000, 16'h8000, 8'h00);
		send_word(OP_POSE, '0, '0, 8'h00);
		// Capturing the last point empties the table.
		send_word(OP_POSE, '0, '0, 8'h00);
		send_word(OP_POSE, '0, '0, 8'h00);

		// A zero radius never captures, not even at distance zero. A write to an
		// unused register index must leave the radius alone.
		settle();
		apb_access(1'b1, ADDR_RADIUS, '0);
		apb_access(1'b1, ADDR_SPARE, $urandom);
		apb_access(1'b0, ADDR_RADIUS, '0);
		send_word(OP_INSERT, 16'h1234, 16'h1234, 8'h3C);
		send_word(OP_POSE, 16'h1234, 16'h1234, 8'h00);

		// The largest radius captures a full-range offset on one axis but not a
		// diagonal to the far corner.
		settle();
		apb_access(1'b1, ADDR_RADIUS, '1);
		send_word(OP_POSE, '0, '0, 8'h00);
		send_word(OP_INSERT, '0, '0, 8'h01);
		send_word(OP_POSE, COORD_MAX, COORD_MAX, 8'h00);
		send_word(OP_POSE, COORD_MAX, '0, 8'h00);

		// The comparison is strict: a distance equal to the radius is no capture.
		settle();
		apb_access(1'b1, ADDR_RADIUS, 32'd1);
		send_word(OP_INSERT, 16'd100, 16'd100, 8'h02);
		send_word(OP_POSE, 16'd101, 16'd100, 8'h00);
		send_word(OP_POSE, 16'd100, 16'd100, 8'h00);

		// Random phases. Each one sets a radius while the block is idle, then sends
		// words with its own insert share and spread. The zero-radius phase fills the
		// table and runs into drops, the largest radius drains it again, phase two
		// runs with no idling, and phase four carries the long receiver hold-off.
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: begin radius = RADIUS_RESET; insert_pct = 60; spread = 3000; end
				1: begin radius = '0; insert_pct = 75; spread = 65535; end
				2: begin radius = '1; insert_pct = 35; spread = 65535; end
				3: begin radius = 32'h0100_0000; insert_pct = 55; spread = 8000; end
				4: begin radius = RADIUS_RESET; insert_pct = 50; spread = 2000; end
				5: begin radius = $urandom; insert_pct = 50; spread = 20000; end
				6: begin radius = 32'd1; insert_pct = 50; spread = 300; end
				default: begin radius = RADIUS_RESET; insert_pct = 55; spread = 5000; end
			endcase
			apb_access(1'b1, ADDR_RADIUS, radius);
			apb_access(1'b0, ADDR_RADIUS, '0);
			center_x = COORD_W'($urandom);
			center_y = COORD_W'($urandom);
			quiet_mode = (ph == 2);
			if (ph == 4)
				hold_req = 1'b1;
			repeat (PHASE_WORDS) send_random(insert_pct, spread);
		end

		// Everything has been taken in; wait for the last results, then a little more
		// so that any stray result word would still be seen.
		settle();
		quiet_mode = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("nearest_target_tracker_tb OK");
		else
			$display("nearest_target_tracker_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/ntt_pkg.sv
rtl/ntt_ram.sv
rtl/ntt_dist.sv
rtl/nearest_target_tracker.sv
tb/nearest_target_tracker_checker.sv
tb/nearest_target_tracker_tb.sv
